@@ hdl/tlrq_pkg.sv @@
package tlrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 9;
    localparam int KEY_W  = 32;
    localparam int PKEY_W = 8;
    localparam int STAT_W = 2;

    localparam int SJF_W = ID_W + KEY_W;
    localparam int PQ_W  = ID_W + PKEY_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 3;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_PICKED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_PICK   = 1'b1;

    // A priority of -1 routes the task to the shortest-job queue.
    localparam logic [PRIO_W-1:0] SJF_PRIO = '1;

endpackage

@@ hdl/two_level_ready_queue.sv @@
// A full-queue insert or a pick with both queues empty goes from the idle state straight to the
// done state; any other pick passes through the pop state, an insert into an empty queue through the place state.
// An insert into a queue holding entries moves one entry a cycle through the queue RAM's single
// write port under the shared key comparator in the scan state, then writes the new entry in the place state.
// A new word is taken once the previous result has moved into the output register.
// Reset clears the state, the queue heads and counts and the output valid; RAM is not cleared.
module two_level_ready_queue
    import tlrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // task_id[7:0], task_priority[16:8], burst_time[48:17], zeros above.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action.
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // picked_id.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0], from_sjf[2].
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     sjf_head_reg, sjf_head_next;
    logic [CW-1:0]     sjf_cnt_reg, sjf_cnt_next;
    logic [IW-1:0]     prio_head_reg, prio_head_next;
    logic [CW-1:0]     prio_cnt_reg, prio_cnt_next;
    logic              sel_sjf_reg, sel_sjf_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic              res_sjf_reg, res_sjf_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_sjf_reg, out_sjf_next;

    logic              in_action;
    logic [ID_W-1:0]   in_id;
    logic [PRIO_W-1:0] in_prio;
    logic [KEY_W-1:0]  in_burst;
    logic              in_to_sjf;
    logic [KEY_W-1:0]  in_key;
    logic [CW-1:0]     ins_cnt;
    logic [IW-1:0]     ins_head;
    logic [IW-1:0]     ins_last;

    logic [SJF_W-1:0]  sjf_rd;
    logic [PQ_W-1:0]   pq_rd;
    logic [KEY_W-1:0]  cur_rd_key;
    logic [ID_W-1:0]   cur_rd_id;
    logic              rd_gt_key;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic              wr_any;
    logic              sjf_wr_en;
    logic              pq_wr_en;
    logic [SJF_W-1:0]  sjf_wr_data;
    logic [PQ_W-1:0]   pq_wr_data;

    function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p);
        return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] dec_ptr(input logic [IW-1:0] p);
        return (p == '0) ? IW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Slot of the last entry: head + count - 1, wrapped around the ring.
    function automatic logic [IW-1:0] last_ptr(input logic [IW-1:0] h, input logic [CW-1:0] c);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(c) - SW'(1);
        if (s >= SW'(QUEUE_DEPTH))
        begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign in_action = s_axis_tuser[0];
    assign in_id     = s_axis_tdata[7:0];
    assign in_prio   = s_axis_tdata[16:8];
    assign in_burst  = s_axis_tdata[48:17];
    assign in_to_sjf = (in_prio == SJF_PRIO);
    assign in_key    = in_to_sjf ? in_burst
                     : (in_prio[PRIO_W-1] ? '0 : KEY_W'(in_prio[PKEY_W-1:0]));
    assign ins_cnt   = in_to_sjf ? sjf_cnt_reg : prio_cnt_reg;
    assign ins_head  = in_to_sjf ? sjf_head_reg : prio_head_reg;
    assign ins_last  = last_ptr(ins_head, ins_cnt);

    assign cur_rd_key = sel_sjf_reg ? sjf_rd[KEY_W-1:0] : KEY_W'(pq_rd[PKEY_W-1:0]);
    assign cur_rd_id  = sel_sjf_reg ? sjf_rd[SJF_W-1:KEY_W] : pq_rd[PQ_W-1:PKEY_W];
    assign rd_gt_key  = (cur_rd_key > key_reg);

    always_comb
    begin
        rd_addr = pos_reg;
        if (state_reg == S_IDLE)
        begin
            if (in_action == ACT_PICK)
            begin
                rd_addr = (sjf_cnt_reg != '0) ? sjf_head_reg : prio_head_reg;
            end
            else
            begin
                rd_addr = ins_last;
            end
        end
        else if (state_reg == S_SCAN)
        begin
            rd_addr = dec_ptr(pos_reg);
        end
    end

    assign wr_addr     = (state_reg == S_SCAN) ? inc_ptr(pos_reg) : pos_reg;
    assign wr_any      = ((state_reg == S_SCAN) && rd_gt_key) || (state_reg == S_PLACE);
    assign sjf_wr_en   = wr_any && sel_sjf_reg;
    assign pq_wr_en    = wr_any && !sel_sjf_reg;
    assign sjf_wr_data = (state_reg == S_SCAN) ? sjf_rd : {id_reg, key_reg};
    assign pq_wr_data  = (state_reg == S_SCAN) ? pq_rd : {id_reg, key_reg[PKEY_W-1:0]};

    tlrq_ram #(
        .WIDTH (SJF_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_sjf_ram (
        .clk     (clk),
        .wr_en   (sjf_wr_en),
        .wr_addr (wr_addr),
        .wr_data (sjf_wr_data),
        .rd_addr (rd_addr),
        .rd_data (sjf_rd)
    );

    tlrq_ram #(
        .WIDTH (PQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pq_ram (
        .clk     (clk),
        .wr_en   (pq_wr_en),
        .wr_addr (wr_addr),
        .wr_data (pq_wr_data),
        .rd_addr (rd_addr),
        .rd_data (pq_rd)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = {out_sjf_reg, out_status_reg};

    always_comb
    begin
        state_next      = state_reg;
        sjf_head_next   = sjf_head_reg;
        sjf_cnt_next    = sjf_cnt_reg;
        prio_head_next  = prio_head_reg;
        prio_cnt_next   = prio_cnt_reg;
        sel_sjf_next    = sel_sjf_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_sjf_next    = res_sjf_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_sjf_next    = out_sjf_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    id_next      = in_id;
                    key_next     = in_key;
                    res_id_next  = '0;
                    res_sjf_next = 1'b0;
                    if (in_action == ACT_PICK)
                    begin
                        if (sjf_cnt_reg != '0)
                        begin
                            sel_sjf_next = 1'b1;
                            state_next   = S_POP;
                        end
                        else if (prio_cnt_reg != '0)
                        begin
                            sel_sjf_next = 1'b0;
                            state_next   = S_POP;
                        end
                        else
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        sel_sjf_next = in_to_sjf;
                        if (ins_cnt == CW'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (ins_cnt == '0)
                        begin
                            pos_next   = ins_head;
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            pos_next   = ins_last;
                            left_next  = ins_cnt;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // Entries with a larger key move up one slot; equal keys stay ahead.
                if (rd_gt_key)
                begin
                    left_next = left_reg - 1'b1;
                    if (left_reg == CW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        pos_next = dec_ptr(pos_reg);
                    end
                end
                else
                begin
                    pos_next   = inc_ptr(pos_reg);
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (sel_sjf_reg)
                begin
                    sjf_cnt_next = sjf_cnt_reg + 1'b1;
                end
                else
                begin
                    prio_cnt_next = prio_cnt_reg + 1'b1;
                end
                res_status_next = ST_INSERTED;
                state_next      = S_DONE;
            end
            S_POP:
            begin
                res_id_next     = cur_rd_id;
                res_sjf_next    = sel_sjf_reg;
                res_status_next = ST_PICKED;
                if (sel_sjf_reg)
                begin
                    sjf_head_next = inc_ptr(sjf_head_reg);
                    sjf_cnt_next  = sjf_cnt_reg - 1'b1;
                end
                else
                begin
                    prio_head_next = inc_ptr(prio_head_reg);
                    prio_cnt_next  = prio_cnt_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_sjf_next    = res_sjf_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sjf_head_reg  <= '0;
            sjf_cnt_reg   <= '0;
            prio_head_reg <= '0;
            prio_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sjf_head_reg  <= sjf_head_next;
            sjf_cnt_reg   <= sjf_cnt_next;
            prio_head_reg <= prio_head_next;
            prio_cnt_reg  <= prio_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_sjf_reg    <= sel_sjf_next;
        pos_reg        <= pos_next;
        left_reg       <= left_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_sjf_reg    <= res_sjf_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_sjf_reg    <= out_sjf_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sjf_cnt_reg <= CW'(QUEUE_DEPTH)) && (prio_cnt_reg <= CW'(QUEUE_DEPTH)))
        else $error("queue count above depth");

    a_one_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sjf_cnt_reg) |-> $stable(prio_cnt_reg))
        else $error("both queue counts changed in one cycle");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result word appeared outside the done state");

    a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (left_reg != '0))
        else $error("scan with no entries left");

endmodule

@@ hdl/tlrq_ram.sv @@
module tlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
